// ----- rtl/core/crs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;
    localparam int OUT_W = 32;

    typedef enum logic [1:0] {
        OP_2X2  = 2'd0,
        OP_3X2  = 2'd1,
        OP_3X3  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    // Result of one division: value and saturation flag.
    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             clip;
    } t_quot;
endpackage
`default_nettype wire

// ----- rtl/core/crs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Front end: unpacks the lanes, forms the determinants and picks the row pair.
// Stage 1 registers every 2x2 minor that any mode needs; stage 2 combines the
// minors into the 3x3 determinants or selects them, and makes the row-pair selection.
module crs_front #(
    parameter int CW = 16,
    parameter int CF = 8,
    parameter int DW = 3 * CW + 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [47:0]          i_col_first,
    input  wire logic [47:0]          i_col_second,
    input  wire logic [47:0]          i_col_third,
    input  wire logic [47:0]          i_col_rhs,
    input  wire logic [15:0]          i_thr,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [1:0]                o_opcode,
    output logic signed [DW-1:0]      o_den,
    output logic signed [DW-1:0]      o_num1,
    output logic signed [DW-1:0]      o_num2,
    output logic signed [DW-1:0]      o_num3
);
    localparam int PW = 2 * CW;
    localparam int MW = PW + 1;
    localparam int CMPW = MW + 2 * CF + 17;

    // Column pairs of the stored minors.
    localparam int P01 = 0;
    localparam int P02 = 1;
    localparam int P12 = 2;
    // Pairs with the right-hand column, kept for the y and z rows only.
    localparam int Q03 = 0;
    localparam int Q13 = 1;
    localparam int Q23 = 2;
    // Row pairs.
    localparam logic [1:0] RP_XY = 2'd0;
    localparam logic [1:0] RP_XZ = 2'd1;
    localparam logic [1:0] RP_YZ = 2'd2;

    logic signed [CW-1:0] c [4][3];
    logic [47:0] cols [4];
    assign cols[0] = i_col_first;
    assign cols[1] = i_col_second;
    assign cols[2] = i_col_third;
    assign cols[3] = i_col_rhs;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 3; j++) begin
                if ((j + 1) * CW <= 48) begin
                    c[k][j] = cols[k][j*CW +: CW];
                end else if (j * CW < 48) begin
                    c[k][j] = CW'(cols[k] >> (j * CW));
                end else begin
                    c[k][j] = '0;
                end
            end
        end
    end

    // Minor of columns a and b: a0 and b0 sit on the first row, a1 and b1 on the second.
    function automatic logic signed [MW-1:0] det2(
        input logic signed [CW-1:0] a0, input logic signed [CW-1:0] a1,
        input logic signed [CW-1:0] b0, input logic signed [CW-1:0] b1);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] q;
        p = a0 * b1;
        q = a1 * b0;
        return MW'(p) - MW'(q);
    endfunction

    // Expansion along the x row from the x lanes and the y-z minors.
    function automatic logic signed [DW-1:0] det3x(
        input logic signed [CW-1:0] xa, input logic signed [CW-1:0] xb,
        input logic signed [CW-1:0] xc, input logic signed [MW-1:0] mbc,
        input logic signed [MW-1:0] mac, input logic signed [MW-1:0] mab);
        logic signed [CW+MW-1:0] ta;
        logic signed [CW+MW-1:0] tb;
        logic signed [CW+MW-1:0] tc;
        ta = xa * mbc;
        tb = xb * mac;
        tc = xc * mab;
        return DW'(ta) - DW'(tb) + DW'(tc);
    endfunction

    logic s1_ready, s2_ready;
    logic r_v1, r_v2;
    logic [1:0] r_op1, r_op2;
    logic signed [CW-1:0] r_x [4];
    logic signed [MW-1:0] r_m2 [3][3]; // [column pair][row pair]
    logic signed [MW-1:0] r_m3 [3];

    assign o_valid  = r_v2;
    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_ready) begin
            r_v1 <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r_op1 <= i_opcode;
            for (int k = 0; k < 4; k++) begin
                r_x[k] <= c[k][0];
            end
            r_m2[P01][RP_XY] <= det2(c[0][0], c[0][1], c[1][0], c[1][1]);
            r_m2[P01][RP_XZ] <= det2(c[0][0], c[0][2], c[1][0], c[1][2]);
            r_m2[P01][RP_YZ] <= det2(c[0][1], c[0][2], c[1][1], c[1][2]);
            r_m2[P02][RP_XY] <= det2(c[0][0], c[0][1], c[2][0], c[2][1]);
            r_m2[P02][RP_XZ] <= det2(c[0][0], c[0][2], c[2][0], c[2][2]);
            r_m2[P02][RP_YZ] <= det2(c[0][1], c[0][2], c[2][1], c[2][2]);
            r_m2[P12][RP_XY] <= det2(c[1][0], c[1][1], c[2][0], c[2][1]);
            r_m2[P12][RP_XZ] <= det2(c[1][0], c[1][2], c[2][0], c[2][2]);
            r_m2[P12][RP_YZ] <= det2(c[1][1], c[1][2], c[2][1], c[2][2]);
            r_m3[Q03] <= det2(c[0][1], c[0][2], c[3][1], c[3][2]);
            r_m3[Q13] <= det2(c[1][1], c[1][2], c[3][1], c[3][2]);
            r_m3[Q23] <= det2(c[2][1], c[2][2], c[3][1], c[3][2]);
        end
    end

    logic signed [DW-1:0] n_den, n_n1, n_n2, n_n3;
    logic signed [MW-1:0] dxy, dxz;
    logic [CMPW-1:0] thr_s;
    logic nz_xy, nz_xz;
    logic [1:0] sel;
    logic [MW-1:0] mag_xy, mag_xz;

    always_comb begin
        dxy = r_m2[P01][RP_XY];
        dxz = r_m2[P01][RP_XZ];
        mag_xy = dxy < 0 ? -dxy : dxy;
        mag_xz = dxz < 0 ? -dxz : dxz;
        thr_s = CMPW'(i_thr) << (2 * CF);
        nz_xy = (CMPW'(mag_xy) << 16) <= thr_s;
        nz_xz = (CMPW'(mag_xz) << 16) <= thr_s;
        sel = RP_XY;
        if (r_op1 == crs_pkg::OP_3X2) begin
            if (!nz_xy) begin
                sel = RP_XY;
            end else if (!nz_xz) begin
                sel = RP_XZ;
            end else begin
                sel = RP_YZ;
            end
        end
        n_den = '0;
        n_n1  = '0;
        n_n2  = '0;
        n_n3  = '0;
        case (r_op1)
            crs_pkg::OP_2X2, crs_pkg::OP_3X2: begin
                n_den = DW'(r_m2[P01][sel]);
                n_n1  = -DW'(r_m2[P12][sel]);
                n_n2  = DW'(r_m2[P02][sel]);
            end
            crs_pkg::OP_3X3: begin
                n_den = det3x(r_x[0], r_x[1], r_x[2], r_m2[P12][RP_YZ],
                              r_m2[P02][RP_YZ], r_m2[P01][RP_YZ]);
                n_n1  = det3x(r_x[3], r_x[1], r_x[2], r_m2[P12][RP_YZ],
                              -r_m3[Q23], -r_m3[Q13]);
                n_n2  = det3x(r_x[0], r_x[3], r_x[2], -r_m3[Q23],
                              r_m2[P02][RP_YZ], r_m3[Q03]);
                n_n3  = det3x(r_x[0], r_x[1], r_x[3], r_m3[Q13],
                              r_m3[Q03], r_m2[P01][RP_YZ]);
            end
            default: begin
                n_den = '0;
                n_n1  = '0;
                n_n2  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_ready) begin
            r_v2 <= r_v1;
        end
        if (s2_ready && r_v1) begin
            r_op2 <= r_op1;
            o_den <= n_den;
            o_num1 <= n_n1;
            o_num2 <= n_n2;
            o_num3 <= n_n3;
        end
    end
    assign o_opcode = r_op2;
endmodule
`default_nettype wire

// ----- rtl/core/crs_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue between the determinant front end and the divider back end.
module crs_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ----- rtl/core/crs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Back end: three pipelined restoring dividers, one quotient bit per stage.
module crs_back #(
    parameter int DW = 51,
    parameter int RF = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_opcode,
    input  wire logic signed [DW-1:0] i_den,
    input  wire logic signed [DW-1:0] i_num1,
    input  wire logic signed [DW-1:0] i_num2,
    input  wire logic signed [DW-1:0] i_num3,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [31:0]     o_sol_x,
    output logic signed [31:0]     o_sol_y,
    output logic signed [31:0]     o_sol_z,
    output logic                   o_singular,
    output logic                   o_clipped
);
    // Dividend magnitude fits DW-1+RF bits; quotient bits beyond 33 only mean saturation.
    localparam int NW = DW + RF;
    localparam int QB = 34;
    localparam int NS = QB;

    logic stall;
    assign stall = o_valid && !i_ready;
    assign o_ready = !stall;

    logic [NS:0] r_v;
    logic [1:0] r_op [NS+1];
    logic r_zero [NS+1];
    logic [DW-1:0] r_d [NS+1];
    logic [NW-1:0] r_rem [3][NS+1];
    logic r_neg [3][NS+1];
    logic r_hi [3][NS+1];
    logic [QB-1:0] r_q [3][NS+1];

    logic [NW-1:0] mag_n [3];
    logic signed [DW-1:0] nums [3];
    logic [DW-1:0] dmag;
    assign nums[0] = i_num1;
    assign nums[1] = i_num2;
    assign nums[2] = i_num3;
    assign dmag = i_den < 0 ? DW'(-i_den) : DW'(i_den);

    always_comb begin
        for (int u = 0; u < 3; u++) begin
            mag_n[u] = NW'(nums[u] < 0 ? DW'(-nums[u]) : DW'(nums[u])) << RF;
        end
    end

    // Stage 0 precomputes the high quotient part: any quotient bit at or above bit QB means overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (!stall) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
        if (!stall) begin
            r_op[0] <= i_opcode;
            r_zero[0] <= i_den == '0;
            r_d[0] <= dmag;
            for (int u = 0; u < 3; u++) begin
                r_neg[u][0] <= (nums[u] < 0) != (i_den < 0);
                r_hi[u][0] <= (mag_n[u] >> QB) >= NW'(dmag) && dmag != '0;
                r_rem[u][0] <= mag_n[u];
                r_q[u][0] <= '0;
            end
            for (int s = 0; s < NS; s++) begin
                r_op[s+1] <= r_op[s];
                r_zero[s+1] <= r_zero[s];
                r_d[s+1] <= r_d[s];
                for (int u = 0; u < 3; u++) begin
                    logic [NW-1:0] dsh;
                    dsh = NW'(r_d[s]) << (QB - 1 - s);
                    r_neg[u][s+1] <= r_neg[u][s];
                    r_hi[u][s+1] <= r_hi[u][s];
                    if (!r_hi[u][s] && (NW'(r_d[s]) << (QB-1-s)) >> (QB-1-s) == NW'(r_d[s])
                        && r_rem[u][s] >= dsh) begin
                        r_rem[u][s+1] <= r_rem[u][s] - dsh;
                        r_q[u][s+1] <= r_q[u][s] | (QB'(1) << (QB - 1 - s));
                    end else begin
                        r_rem[u][s+1] <= r_rem[u][s];
                        r_q[u][s+1] <= r_q[u][s];
                    end
                end
            end
        end
    end

    function automatic crs_pkg::t_quot sat(input logic hi, input logic [QB-1:0] q,
                                           input logic neg);
        crs_pkg::t_quot r;
        logic [QB-1:0] lim;
        lim = neg ? QB'(34'h080000000) : QB'(34'h07FFFFFFF);
        if (hi || q > lim) begin
            r.clip = 1'b1;
            r.value = neg ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            r.clip = 1'b0;
            r.value = neg ? 32'(-q) : q[31:0];
        end
        return r;
    endfunction

    crs_pkg::t_quot qx, qy, qz;
    always_comb begin
        qx = sat(r_hi[0][NS], r_q[0][NS], r_neg[0][NS]);
        qy = sat(r_hi[1][NS], r_q[1][NS], r_neg[1][NS]);
        qz = sat(r_hi[2][NS], r_q[2][NS], r_neg[2][NS]);
        o_valid = r_v[NS];
        o_sol_x = '0;
        o_sol_y = '0;
        o_sol_z = '0;
        o_singular = 1'b0;
        o_clipped = 1'b0;
        if (r_op[NS] != crs_pkg::OP_NONE) begin
            if (r_zero[NS]) begin
                o_singular = 1'b1;
            end else begin
                o_sol_x = qx.value;
                o_sol_y = qy.value;
                if (r_op[NS] == crs_pkg::OP_3X3) begin
                    o_sol_z = qz.value;
                end
                o_clipped = qx.clip || qy.clip ||
                            (r_op[NS] == crs_pkg::OP_3X3 && qz.clip);
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/cramer_rule_small_solver_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Small linear-system solver by Cramer's rule.
// Input channel: i_valid/o_ready carries an opcode and four packed columns of
// signed Q8.8 lanes (x, y, z). Opcode 0 solves 2x2, 1 solves an overdetermined
// 3x2 with row-pair fallback, 2 solves 3x3; opcode 3 returns all zeros.
// Output channel: o_valid/i_ready carries three Q16.16 unknowns and the
// singular and clipped flags, one result per input transfer, in order.
// Configuration: i_cfg_valid/o_cfg_ready writes zero_threshold (always ready).
// An item passes 38 register stages: two determinant stages, one queue slot,
// a sign and overflow stage and 34 divider stages that each resolve one
// quotient bit. Throughput is one system per cycle while the receiver takes
// results; every stage then takes a new item each cycle.
// When the receiver stalls the divider holds, the queue fills and then the
// front end stops taking transfers. Reset empties every stage and clears the
// threshold to zero.
module cramer_rule_small_solver_core #(
    parameter int COEF_WIDTH = 16,
    parameter int COEF_FRAC = 8,
    parameter int RESULT_FRAC = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [47:0] i_col_first,
    input  wire logic [47:0] i_col_second,
    input  wire logic [47:0] i_col_third,
    input  wire logic [47:0] i_col_rhs,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_sol_x,
    output logic signed [31:0] o_sol_y,
    output logic signed [31:0] o_sol_z,
    output logic             o_singular,
    output logic             o_clipped
);
    localparam int DW = 3 * COEF_WIDTH + 3;
    localparam int QW = 2 + 4 * DW;

    logic [15:0] r_thr;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    logic f_valid, f_ready, b_valid, b_ready;
    logic [1:0] f_op, b_op;
    logic signed [DW-1:0] f_den, f_n1, f_n2, f_n3, b_den, b_n1, b_n2, b_n3;

    crs_front #(.CW(COEF_WIDTH), .CF(COEF_FRAC), .DW(DW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_col_first(i_col_first), .i_col_second(i_col_second),
        .i_col_third(i_col_third), .i_col_rhs(i_col_rhs), .i_thr(r_thr),
        .o_valid(f_valid), .i_ready(f_ready), .o_opcode(f_op), .o_den(f_den),
        .o_num1(f_n1), .o_num2(f_n2), .o_num3(f_n3)
    );

    crs_fifo #(.W(QW)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .o_ready(f_ready),
        .i_data({f_op, f_den, f_n1, f_n2, f_n3}), .o_valid(b_valid),
        .i_ready(b_ready), .o_data({b_op, b_den, b_n1, b_n2, b_n3})
    );

    crs_back #(.DW(DW), .RF(RESULT_FRAC)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(b_valid), .o_ready(b_ready),
        .i_opcode(b_op), .i_den(b_den), .i_num1(b_n1), .i_num2(b_n2), .i_num3(b_n3),
        .o_valid(o_valid), .i_ready(i_ready), .o_sol_x(o_sol_x), .o_sol_y(o_sol_y),
        .o_sol_z(o_sol_z), .o_singular(o_singular), .o_clipped(o_clipped)
    );

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_sol_x == 0 && o_sol_y == 0 && o_sol_z == 0 && !o_clipped)
        else $error("singular result carries nonzero fields");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sol_x) && $stable(o_singular))
        else $error("stalled result changed");
    a_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(r_thr))
        else $error("threshold changed without a write");
endmodule
`default_nettype wire
